### hdl/bdhd_pkg.sv
// Shared constants, command codes and lane control types for the button debouncer.
package bdhd_pkg;

  localparam int NUM_BUTTONS = 6;
  localparam int PIN_W       = 6;
  localparam int IDX_W       = 3;
  localparam int IDX_RANGE   = 2 ** IDX_W;
  localparam int CMD_W       = 2;
  localparam int CNT_W       = 16;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0] HOLD_RESET = 16'd100;

  // Register word index, taken from paddr[2].
  localparam logic REG_HOLD_TICKS = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_READ_PRESS = 2'd1,
    CMD_READ_HOLD  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic tick;
    logic raw;
    logic clr_press;
    logic clr_hold;
  } lane_ctrl_t;

  typedef struct packed {
    logic stable_q;
    logic stable_d;
    logic press_q;
    logic hold_q;
  } lane_stat_t;

endpackage

### hdl/bdhd_cfg_regs.sv
// Configuration register block holding the hold period, written over the APB-style port.
module bdhd_cfg_regs
  import bdhd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  hold_ticks_o
);

  logic [CNT_W-1:0] hold_ticks_q;
  logic [CNT_W-1:0] hold_ticks_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_HOLD_TICKS);

  always_comb begin
    hold_ticks_d = hold_ticks_q;
    if (wr_en) begin
      hold_ticks_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_RESET;
    end else begin
      hold_ticks_q <= hold_ticks_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HOLD_TICKS) begin
      prdata = {{(DATA_W-CNT_W){1'b0}}, hold_ticks_q};
    end
  end

  assign hold_ticks_o = hold_ticks_q;

endmodule

### hdl/bdhd_lane.sv
// One button lane: two-sample debounce, hold countdown, and sticky press and hold flags.
module bdhd_lane
  import bdhd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lane_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] hold_ticks_i,
  output lane_stat_t       stat_o
);

  logic             prev_q,   prev_d;
  logic             stable_q, stable_d;
  logic             press_q,  press_d;
  logic             hold_q,   hold_d;
  logic [CNT_W-1:0] cnt_q,    cnt_d;
  logic             agree;

  assign agree = (ctrl_i.raw == prev_q);

  always_comb begin
    prev_d   = prev_q;
    stable_d = stable_q;
    press_d  = press_q;
    hold_d   = hold_q;
    cnt_d    = cnt_q;
    if (ctrl_i.tick) begin
      prev_d = ctrl_i.raw;
      if (agree && (stable_q != ctrl_i.raw)) begin
        stable_d = ctrl_i.raw;
        if (!ctrl_i.raw) begin
          // Fresh press: arm the countdown and latch the press event.
          cnt_d   = hold_ticks_i;
          press_d = 1'b1;
        end else begin
          hold_d = 1'b0;
        end
      end else if (agree && !ctrl_i.raw) begin
        // Steady press: count down, and on expiry reload so holds repeat.
        if (cnt_q <= CNT_W'(1)) begin
          cnt_d  = hold_ticks_i;
          hold_d = 1'b1;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
    end
    if (ctrl_i.clr_press) begin
      press_d = 1'b0;
    end
    if (ctrl_i.clr_hold) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b1;
      stable_q <= 1'b1;
      press_q  <= 1'b0;
      hold_q   <= 1'b0;
      cnt_q    <= HOLD_RESET;
    end else begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      press_q  <= press_d;
      hold_q   <= hold_d;
      cnt_q    <= cnt_d;
    end
  end

  assign stat_o.stable_q = stable_q;
  assign stat_o.stable_d = stable_d;
  assign stat_o.press_q  = press_q;
  assign stat_o.hold_q   = hold_q;

endmodule

### hdl/button_debounce_hold_detect.sv
// Top level of the button debouncer with press and repeating hold detection.
//
// This block debounces a bank of active-low push buttons and reports press and
// long-press (hold) events. Each request on the slave stream is either a sample
// tick, which carries the raw pin levels, or a query that reads and clears one
// button's sticky press or hold flag. A button's level is accepted only when two
// successive ticks agree. A debounced press sets the press flag and loads the
// button's countdown from the hold_ticks register; every further steady pressed
// tick counts it down, and on expiry it reloads and sets the hold flag, so holds
// repeat for as long as the button is held. A debounced release clears the hold
// flag. Every request produces exactly one result on the master stream, carrying
// the queried flag (zero for ticks and unknown commands or buttons) and the
// debounced pressed state after the request. A request is captured in an input
// register, and then all button lanes update in parallel into the result
// register, so the block takes one request per clock cycle while the master
// stream accepts results; the only thing that slows it is back-pressure on the master
// stream. The hold period register should be written while the block is idle and
// applies from the next countdown load or reload.
module button_debounce_hold_detect
  import bdhd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Slave stream: requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [5:0] pin_levels, [8:6] button_index
  input  logic [CMD_W-1:0]  s_axis_tuser,   // [1:0] command
  // Master stream: results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [0] query_flag, [6:1] debounced_pressed
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0]       hold_ticks;

  logic                   in_valid_q, in_valid_d;
  cmd_e                   in_cmd_q;
  logic [PIN_W-1:0]       in_pins_q;
  logic [IDX_W-1:0]       in_idx_q;
  logic                   in_accept;
  logic                   advance;

  logic                   out_valid_q, out_valid_d;
  logic                   out_flag_q;
  logic [PIN_W-1:0]       out_deb_q;

  lane_ctrl_t             lane_ctrl [NUM_BUTTONS];
  lane_stat_t             lane_stat [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] sel_vec;
  logic [NUM_BUTTONS-1:0] press_vec;
  logic [NUM_BUTTONS-1:0] hold_vec;
  logic [NUM_BUTTONS-1:0] stable_vec;
  logic [PIN_W-1:0]       deb_next;
  logic                   flag_next;
  logic                   is_tick;

  bdhd_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .hold_ticks_o (hold_ticks)
  );

  // The input register moves on whenever the result register is free or drains.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser);
      in_pins_q <= s_axis_tdata[PIN_W-1:0];
      in_idx_q  <= s_axis_tdata[PIN_W+IDX_W-1:PIN_W];
    end
  end

  assign is_tick = advance & (in_cmd_q == CMD_TICK);

  // Button lanes. Buttons without a pin see a released level; buttons that the
  // index field cannot address are never selected by a query.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    if (i < PIN_W) begin : g_pin
      assign lane_ctrl[i].raw = in_pins_q[i];
    end else begin : g_nopin
      assign lane_ctrl[i].raw = 1'b1;
    end
    if (i < IDX_RANGE) begin : g_sel
      assign sel_vec[i] = (in_idx_q == IDX_W'(i));
    end else begin : g_nosel
      assign sel_vec[i] = 1'b0;
    end
    assign lane_ctrl[i].tick      = is_tick;
    assign lane_ctrl[i].clr_press = advance & (in_cmd_q == CMD_READ_PRESS) & sel_vec[i];
    assign lane_ctrl[i].clr_hold  = advance & (in_cmd_q == CMD_READ_HOLD) & sel_vec[i];

    bdhd_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl[i]),
      .hold_ticks_i (hold_ticks),
      .stat_o       (lane_stat[i])
    );

    assign press_vec[i]  = lane_stat[i].press_q;
    assign hold_vec[i]   = lane_stat[i].hold_q;
    assign stable_vec[i] = lane_stat[i].stable_q;
  end

  // Debounced pressed state after this request; only the first PIN_W buttons show.
  for (genvar b = 0; b < PIN_W; b++) begin : g_deb
    if (b < NUM_BUTTONS) begin : g_btn
      assign deb_next[b] = ~lane_stat[b].stable_d;
    end else begin : g_none
      assign deb_next[b] = 1'b0;
    end
  end

  always_comb begin
    case (in_cmd_q)
      CMD_READ_PRESS: flag_next = |(press_vec & sel_vec);
      CMD_READ_HOLD:  flag_next = |(hold_vec & sel_vec);
      default:        flag_next = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_flag_q <= flag_next;
      out_deb_q  <= deb_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_deb_q, out_flag_q};

  // A sample tick always reports a clear query flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_cmd_q == CMD_TICK)) |=> (m_axis_tdata[0] == 1'b0))
    else $error("sample tick produced a set query flag");

  // Requests are refused only when both registers are full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input refused while the pipeline could move");

  // Queries and idle cycles never change the debounced state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_tick |=> $stable(stable_vec))
    else $error("debounced state changed without a sample tick");

  // A hold flag can only be set on a button that is debounced as pressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_vec & stable_vec) == '0)
    else $error("hold flag set on a released button");

endmodule

### verif/testbench.sv
// Self-checking testbench for the button debouncer with press and repeating hold detection.
`timescale 1ns / 1ps

module testbench;
  import bdhd_pkg::*;

  // Command 3 is not decoded by the block. It must return a zero flag and leave all state alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // The hold period register is word 0 of the configuration space.
  localparam logic [ADDR_W-1:0] HOLD_TICKS_ADDR = {REG_HOLD_TICKS, 2'b00};

  // One result as the block reports it. The field order follows the master stream,
  // from the top bit down.
  typedef struct packed {
    logic [PIN_W-1:0] pressed;
    logic             flag;
  } result_t;

  // Tracks the debouncer state, predicts the result of each accepted request, and
  // compares the results that the block returns, in order.
  class debounce_tracker;
    logic [CNT_W-1:0] hold_period;
    logic [PIN_W-1:0] last_sample;
    logic [PIN_W-1:0] settled;
    logic [PIN_W-1:0] press_seen;
    logic [PIN_W-1:0] hold_seen;
    logic [CNT_W-1:0] countdown [NUM_BUTTONS];
    result_t          expected_results [$];
    int               result_count;
    int               fails;

    function new();
      hold_period = HOLD_RESET;
      last_sample = '1;
      settled     = '1;
      press_seen  = '0;
      hold_seen   = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) countdown[i] = HOLD_RESET;
      result_count = 0;
      fails        = 0;
    endfunction

    function void set_hold_period(logic [CNT_W-1:0] value);
      hold_period = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advances the state by one accepted request and queues the expected result.
    function void note_request(logic [CMD_W-1:0] cmd, logic [PIN_W-1:0] pins,
                               logic [IDX_W-1:0] idx);
      result_t want;
      want.flag = 1'b0;
      case (cmd)
        CMD_TICK: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            // A level only counts once two successive samples agree.
            if (pins[i] == last_sample[i]) begin
              if (settled[i] != pins[i]) begin
                settled[i] = pins[i];
                if (!pins[i]) begin
                  countdown[i]  = hold_period;
                  press_seen[i] = 1'b1;
                end else begin
                  hold_seen[i] = 1'b0;
                end
              end else if (!pins[i]) begin
                // A countdown of one or zero expires, so a period of zero acts as one.
                if (countdown[i] <= 1) begin
                  countdown[i] = hold_period;
                  hold_seen[i] = 1'b1;
                end else begin
                  countdown[i] = countdown[i] - 1'b1;
                end
              end
            end
            last_sample[i] = pins[i];
          end
        end
        CMD_READ_PRESS: begin
          if (idx < NUM_BUTTONS) begin
            want.flag       = press_seen[idx];
            press_seen[idx] = 1'b0;
          end
        end
        CMD_READ_HOLD: begin
          if (idx < NUM_BUTTONS) begin
            want.flag      = hold_seen[idx];
            hold_seen[idx] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      want.pressed = ~settled;
      expected_results.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("MISMATCH at result %0d: %s is %0h, expected %0h",
               result_count, what, got, want);
      fails++;
    endtask

    task check_result(logic [7:0] data);
      result_t got;
      result_t want;
      got = data[PIN_W:0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", data, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.flag !== want.flag) report_mismatch("query_flag", got.flag, want.flag);
        if (got.pressed !== want.pressed)
          report_mismatch("debounced_pressed", got.pressed, want.pressed);
      end
      result_count++;
    endtask
  endclass

  // Clock, reset and every input of the block start at known values.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;
  logic [CMD_W-1:0]  s_axis_tuser  = CMD_TICK;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  debounce_tracker ledger = new();

  // Idling behaviour of each side: 0 means none, 1 mostly short gaps, 2 frequent gaps.
  int send_mode  = 1;
  int stall_mode = 1;
  int stall_left = 0;

  button_debounce_hold_detect dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Length of an idle stretch. Most are zero or short, with the occasional long one.
  function automatic int pick_gap(int mode);
    int roll;
    int calm;
    if (mode == 0) return 0;
    calm = (mode == 2) ? 30 : 70;
    roll = $urandom_range(99);
    if (roll < calm) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side. The handshake is sampled at the rising edge, before anything driven
  // at that edge takes effect, and tready is then chosen for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) ledger.check_result(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = pick_gap(stall_mode);
      m_axis_tready <= (stall_left == 0);
    end
  end

  // Offers one request and returns once it has been accepted. The valid line is only
  // lowered when a gap is wanted, so back-to-back requests keep it high throughout.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PIN_W-1:0] pins,
                              input logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap(send_mode);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, idx, pins};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.note_request(cmd, pins, idx);
  endtask

  // Stops offering requests and waits until every expected result has come back,
  // then allows for the pipeline to drain completely.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the hold period. It has a setup phase and then an access phase, and the
  // register takes the value at the edge that ends the access phase.
  task automatic write_hold_ticks(input logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HOLD_TICKS_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_hold_period(value);
  endtask

  // Random traffic built around a pattern of held buttons that changes now and then,
  // so that presses last long enough to reach hold and repeated hold. Some ticks
  // carry contact bounce, and flag queries and unused commands are mixed in.
  task automatic random_phase(input int count, input int change_permille);
    logic [PIN_W-1:0] held;
    logic [PIN_W-1:0] pins;
    logic [IDX_W-1:0] idx;
    int               roll;
    held = '1;
    repeat (count) begin
      if ($urandom_range(999) < change_permille) held = PIN_W'($urandom);
      roll = $urandom_range(99);
      pins = PIN_W'($urandom);
      idx  = IDX_W'($urandom);
      if (roll < 60) begin
        if ($urandom_range(9) != 0) pins = held;
        send_request(CMD_TICK, pins, idx);
      end else if (roll < 96) begin
        // Out-of-range buttons are asked about now and then.
        if ($urandom_range(9) == 0) idx = IDX_W'($urandom_range(NUM_BUTTONS, IDX_RANGE - 1));
        else idx = IDX_W'($urandom_range(NUM_BUTTONS - 1));
        send_request($urandom_range(1) ? CMD_READ_PRESS : CMD_READ_HOLD, pins, idx);
      end else begin
        send_request(CMD_UNUSED, pins, idx);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, at the reset hold period: idle ticks, queries of every kind
    // including out-of-range buttons and the unused command, a press of all buttons,
    // reading and clearing each press flag, bounce that never settles, and release.
    send_request(CMD_TICK, '1, '0);
    send_request(CMD_READ_PRESS, '0, IDX_W'(0));
    send_request(CMD_READ_HOLD, '1, IDX_W'(NUM_BUTTONS - 1));
    send_request(CMD_READ_PRESS, '1, IDX_W'(NUM_BUTTONS));
    send_request(CMD_READ_HOLD, '0, '1);
    send_request(CMD_UNUSED, '0, '1);
    send_request(CMD_TICK, '0, '1);
    send_request(CMD_TICK, '0, '0);
    for (int i = 0; i < NUM_BUTTONS; i++) send_request(CMD_READ_PRESS, '0, IDX_W'(i));
    send_request(CMD_READ_PRESS, '0, IDX_W'(3));
    send_request(CMD_TICK, 6'b101010, '0);
    send_request(CMD_TICK, 6'b010101, '0);
    send_request(CMD_TICK, '1, '0);
    send_request(CMD_TICK, '1, '0);
    settle();

    // The shortest period: every steady pressed tick reports a hold.
    write_hold_ticks(16'd1);
    send_request(CMD_TICK, 6'b111110, '0);
    send_request(CMD_TICK, 6'b111110, '0);
    send_request(CMD_TICK, 6'b111110, '0);
    send_request(CMD_READ_HOLD, '0, IDX_W'(0));
    send_request(CMD_READ_HOLD, '0, IDX_W'(0));
    settle();

    // A period of zero, written while button 0 is still held, behaves like one.
    // Release then clears the hold flag before it is read.
    write_hold_ticks(16'd0);
    send_request(CMD_TICK, 6'b111110, '0);
    send_request(CMD_TICK, 6'b111110, '0);
    send_request(CMD_READ_HOLD, '0, IDX_W'(0));
    send_request(CMD_TICK, 6'b111110, '0);
    send_request(CMD_TICK, '1, '0);
    send_request(CMD_TICK, '1, '0);
    send_request(CMD_READ_HOLD, '0, IDX_W'(0));
    settle();

    // Random part. Long presses at the reset period, with no idling on either side.
    send_mode  = 0;
    stall_mode = 0;
    write_hold_ticks(HOLD_RESET);
    random_phase(400, 3);
    settle();

    // The longest period, so no hold can ever expire here, with heavy idling.
    send_mode  = 2;
    stall_mode = 2;
    write_hold_ticks('1);
    random_phase(150, 30);
    settle();

    // Short periods, where holds and repeats are frequent, under mixed idling.
    for (int p = 0; p < 4; p++) begin
      send_mode  = p % 3;
      stall_mode = (p + 1) % 3;
      write_hold_ticks(CNT_W'($urandom_range(2, 8)));
      random_phase(200, 40);
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (ledger.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
